// File: rtl/bht_pkg.sv
`timescale 1ns / 1ps
// bht_pkg: sizes, codes and entry layout of the biased handle table.
// No dependencies; used by biased_handle_table.
package bht_pkg;

    localparam int SLOTS     = 64;
    localparam int BIAS      = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int STD_SLOTS = 3;
    localparam int COUNT_W   = 11;

    // beat layouts
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [2:0] {
        CMD_ALLOC_FD    = 3'd0,
        CMD_ALLOC_OBJ   = 3'd1,
        CMD_TO_FD       = 3'd2,
        CMD_KIND_OF     = 3'd3,
        CMD_GET_OBJ     = 3'd4,
        CMD_RELEASE_OBJ = 3'd5,
        CMD_RELEASE     = 3'd6,
        CMD_UNKNOWN     = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_INVALID      = 3'd1,
        STS_WRONG_KIND   = 3'd2,
        STS_FULL         = 3'd3,
        STS_BAD_ARG      = 3'd4,
        STS_FIND_CLOSE   = 3'd5,
        STS_NOT_CLOSABLE = 3'd6
    } t_status;

    localparam logic [2:0] KIND_FD     = 3'd0;
    localparam logic [2:0] KIND_FIND   = 3'd1;
    localparam logic [2:0] KIND_MAP    = 3'd2;
    localparam logic [2:0] KIND_PROC   = 3'd3;
    localparam logic [2:0] KIND_CHANGE = 3'd4;

    typedef struct packed {
        logic        hook;
        logic [31:0] object;
        logic        closable;
        logic [15:0] fd;
        logic [2:0]  kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/bht_ram.sv
`timescale 1ns / 1ps
// bht_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/biased_handle_table.sv
`timescale 1ns / 1ps
// biased_handle_table: handle table with biased handles, payload in one RAM.
// Flow: a taken command beat is registered with its RAM read; in S_EXEC the result is
// computed, written back and registered on commit, and no new beat is taken until then.
// A held result does not block the next command beat; only a second finished
// result waits for the first. Reset (i_rst_n low, synchronous) presets slots
// 0-2 as the standard streams, frees all others and zeroes the live count.
module biased_handle_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[2:0] handle_value[66:3] file_desc[82:67] closable_flag[83]
    // object_kind[86:84] object_tag[118:87] has_free_hook[119]
    input  logic [bht_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[2:0] handle_out[34:3] fd_out[50:35] kind_out[53:51]
    // object_out[85:54] free_needed[86] live_count[97:87], zero pad above
    output logic [bht_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import bht_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // ---------------- beat fields ----------------
    logic [2:0]  in_cmd;
    logic [63:0] in_handle;
    logic [15:0] in_fd;
    logic        in_clos;
    logic [2:0]  in_okind;
    logic [31:0] in_tag;
    logic        in_hook;

    assign in_cmd    = s_axis_tdata[2:0];
    assign in_handle = s_axis_tdata[66:3];
    assign in_fd     = s_axis_tdata[82:67];
    assign in_clos   = s_axis_tdata[83];
    assign in_okind  = s_axis_tdata[86:84];
    assign in_tag    = s_axis_tdata[118:87];
    assign in_hook   = s_axis_tdata[119];

    // ---------------- control state ----------------
    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_used, n_used;     // in-use bitmap, doubles as free map
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // free-slot search is registered every cycle; the bitmap only moves on a
    // commit, which always passes through S_IDLE before the next commit
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic                 r_free_any, n_free_any;

    // ---------------- registered command ----------------
    t_cmd                 r_cmd;
    logic [15:0]          r_fd;
    logic                 r_clos;
    logic [2:0]           r_okind;
    logic [31:0]          r_tag;
    logic                 r_hook;
    logic                 r_in_range;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_std_hit;
    logic [1:0]           r_std_fd;

    logic accept, commit;
    assign s_axis_tready = r_state[0];            // S_IDLE
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = r_state[1] && (!r_out_valid || m_axis_tready);

    // ---------------- handle decode at the accept beat ----------------
    logic [63:0]      h_diff;
    logic             h_in_range;
    logic [31:0]      h_lo, h_hi;
    logic             std_hit;
    logic [31:0]      std_diff;

    assign h_diff     = in_handle - 64'(BIAS);
    assign h_in_range = !in_handle[63] && (in_handle >= 64'(BIAS))
                        && (h_diff[63:IDX_W] == '0);
    assign h_lo       = in_handle[31:0];
    assign h_hi       = in_handle[63:32];
    // standard selectors: -10, -11, -12 in the low word, high word not positive
    assign std_hit    = ((h_hi == 32'd0) || h_hi[31])
                        && (h_lo >= 32'hFFFF_FFF4) && (h_lo <= 32'hFFFF_FFF6);
    assign std_diff   = 32'hFFFF_FFF6 - h_lo;

    // ---------------- payload RAM ----------------
    logic             ram_we;
    t_entry           ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    bht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (h_diff[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- lowest free slot from 3 up ----------------
    always_comb begin
        n_free_idx = '0;
        n_free_any = 1'b0;
        for (int i = SLOTS - 1; i >= STD_SLOTS; i--) begin
            if (!r_used[i]) begin
                n_free_idx = IDX_W'(i);
                n_free_any = 1'b1;
            end
        end
    end

    // ---------------- execute ----------------
    t_entry               ent;
    logic                 hit;
    t_status              res_status;
    logic [31:0]          res_handle;
    logic [15:0]          res_fd;
    logic [2:0]           res_kind;
    logic [31:0]          res_obj;
    logic                 res_fneed;
    logic                 alloc_ok;
    logic                 wipe;

    always_comb begin
        // standard stream slots are never written; they keep their preset
        if (r_idx < IDX_W'(STD_SLOTS)) begin
            ent          = '0;
            ent.kind     = KIND_FD;
            ent.fd       = 16'(r_idx);
        end else begin
            ent = t_entry'(ram_rdata);
        end
        hit = r_in_range && r_used[r_idx];

        res_status = STS_OK;
        res_handle = '0;
        res_fd     = '1;
        res_kind   = '0;
        res_obj    = '0;
        res_fneed  = 1'b0;
        alloc_ok   = 1'b0;
        wipe       = 1'b0;
        ram_wdata  = '0;

        case (r_cmd)
            CMD_ALLOC_FD, CMD_ALLOC_OBJ: begin
                if (r_cmd == CMD_ALLOC_FD && r_fd[15]) begin
                    res_status = STS_BAD_ARG;
                end else if (r_cmd == CMD_ALLOC_OBJ && (r_tag == 32'd0
                             || r_okind < KIND_FIND || r_okind > KIND_CHANGE)) begin
                    res_status = STS_BAD_ARG;
                end else if (!r_free_any) begin
                    res_status = STS_FULL;
                end else begin
                    alloc_ok   = 1'b1;
                    res_handle = 32'(r_free_idx) + 32'(BIAS);
                    if (r_cmd == CMD_ALLOC_FD) begin
                        ram_wdata.kind     = KIND_FD;
                        ram_wdata.fd       = r_fd;
                        ram_wdata.closable = r_clos;
                    end else begin
                        ram_wdata.kind     = r_okind;
                        ram_wdata.fd       = '1;
                        ram_wdata.closable = 1'b1;
                        ram_wdata.object   = r_tag;
                        ram_wdata.hook     = r_hook;
                    end
                end
            end
            CMD_TO_FD: begin
                if (r_std_hit) begin
                    res_fd = 16'(r_std_fd);
                end else if (!hit) begin
                    res_status = STS_INVALID;
                end else if (ent.kind != KIND_FD) begin
                    res_status = STS_WRONG_KIND;
                end else begin
                    res_fd = ent.fd;
                end
            end
            CMD_KIND_OF: begin
                if (!hit) begin
                    res_status = STS_INVALID;
                end else begin
                    res_kind = ent.kind;
                end
            end
            CMD_GET_OBJ, CMD_RELEASE_OBJ: begin
                if (!hit) begin
                    res_status = STS_INVALID;
                end else if (ent.kind != r_okind) begin
                    res_status = STS_WRONG_KIND;
                end else begin
                    res_obj = ent.object;
                    wipe    = (r_cmd == CMD_RELEASE_OBJ);
                end
            end
            CMD_RELEASE: begin
                if (!hit) begin
                    res_status = STS_INVALID;
                end else if (ent.kind == KIND_FIND || ent.kind == KIND_CHANGE) begin
                    res_status = STS_FIND_CLOSE;
                end else if (ent.kind == KIND_MAP || ent.kind == KIND_PROC) begin
                    res_obj   = ent.object;
                    res_fneed = ent.hook;
                    wipe      = 1'b1;
                end else if (!ent.closable) begin
                    res_status = STS_NOT_CLOSABLE;
                end else begin
                    res_fd = ent.fd;
                    wipe   = 1'b1;
                end
            end
            default: begin
                res_status = STS_BAD_ARG;
            end
        endcase
    end

    assign ram_we = commit && alloc_ok;

    // bitmap and live count after this command
    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (commit && alloc_ok) begin
            n_used[r_free_idx] = 1'b1;
            n_count            = r_count + COUNT_W'(1);
        end
        if (commit && wipe) begin
            n_used[r_idx] = 1'b0;
            if (r_idx >= IDX_W'(STD_SLOTS) && r_count != '0) begin
                n_count = r_count - COUNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= SLOTS'({STD_SLOTS{1'b1}});
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_free_any  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_count    <= n_count;
            r_free_any <= n_free_any;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (accept) begin
            r_cmd      <= t_cmd'(in_cmd);
            r_fd       <= in_fd;
            r_clos     <= in_clos;
            r_okind    <= in_okind;
            r_tag      <= in_tag;
            r_hook     <= in_hook;
            r_in_range <= h_in_range;
            r_idx      <= h_diff[IDX_W-1:0];
            r_std_hit  <= std_hit;
            r_std_fd   <= std_diff[1:0];
        end
        if (commit) begin
            r_out_data <= OUT_DATA_W'({n_count, res_fneed, res_obj, res_kind,
                                       res_fd, res_handle, res_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for biased_handle_table, command beats in, result beats out.
// Depends on bht_pkg and biased_handle_table; a table model predicts every result beat.
module tb;
    import bht_pkg::*;

    // two copies of the table state: LIVE follows accepted beats, PLAN runs
    // ahead at generation time so stimulus can aim at entries that exist
    localparam int LIVE           = 0;
    localparam int PLAN           = 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 62;

    // command beat, first field in the low bits
    typedef struct packed {
        logic        hook;
        logic [31:0] tag;
        logic [2:0]  okind;
        logic        closable;
        logic [15:0] fdesc;
        logic [63:0] handle;
        t_cmd        cmd;
    } t_cmd_beat;

    // result beat, zero pad on top
    typedef struct packed {
        logic [OUT_DATA_W-99:0] pad;
        logic [COUNT_W-1:0]     live;
        logic                   free_needed;
        logic [31:0]            object;
        logic [2:0]             kind;
        logic [15:0]            fd;
        logic [31:0]            handle;
        logic [2:0]             status;
    } t_rsp_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    // cmd, handle_value, file_desc, closable_flag, object_kind, object_tag, has_free_hook
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, handle_out, fd_out, kind_out, object_out, free_needed, live_count, pad
    wire  [OUT_DATA_W-1:0] m_axis_tdata;

    // table model state
    logic               ent_used     [2][SLOTS];
    logic [2:0]         ent_kind     [2][SLOTS];
    logic [15:0]        ent_fd       [2][SLOTS];
    logic               ent_closable [2][SLOTS];
    logic [31:0]        ent_object   [2][SLOTS];
    logic               ent_hook     [2][SLOTS];
    logic [COUNT_W-1:0] live_cnt     [2];

    t_cmd_beat cmd_q[$];        // commands waiting for the driver
    t_rsp_beat expected_q[$];   // predicted result beats, oldest first
    int        err_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_go = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    biased_handle_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic void reset_table(input int v);
        for (int i = 0; i < SLOTS; i++) begin
            ent_used[v][i]     = (i < STD_SLOTS);
            ent_kind[v][i]     = KIND_FD;
            ent_fd[v][i]       = (i < STD_SLOTS) ? 16'(i) : 16'hFFFF;
            ent_closable[v][i] = 1'b0;
            ent_object[v][i]   = '0;
            ent_hook[v][i]     = 1'b0;
        end
        live_cnt[v] = '0;
    endfunction

    function automatic int lowest_free(input int v);
        for (int i = STD_SLOTS; i < SLOTS; i++)
            if (!ent_used[v][i]) return i;
        return -1;
    endfunction

    // slot of a valid in-use handle, or -1; handles are signed 64-bit
    function automatic int decode_handle(input int v, input logic [63:0] h);
        logic [63:0] idx;
        if (h[63] || h < 64'(BIAS)) return -1;
        idx = h - 64'(BIAS);
        if (idx >= 64'(SLOTS)) return -1;
        if (!ent_used[v][idx]) return -1;
        return int'(idx);
    endfunction

    // the standard-stream slots never count towards the live total
    function automatic void wipe_entry(input int v, input int s);
        if (ent_used[v][s] && s >= STD_SLOTS && live_cnt[v] != 0)
            live_cnt[v] = live_cnt[v] - 1'b1;
        ent_used[v][s]     = 1'b0;
        ent_kind[v][s]     = KIND_FD;
        ent_fd[v][s]       = 16'hFFFF;
        ent_closable[v][s] = 1'b0;
        ent_object[v][s]   = '0;
        ent_hook[v][s]     = 1'b0;
    endfunction

    // apply one command to table copy v and return the result beat it yields
    function automatic t_rsp_beat step_table(input int v, input t_cmd_beat c);
        t_rsp_beat   r;
        int          s;
        logic [31:0] lo;
        logic [31:0] hi;
        r        = '0;
        r.status = STS_OK;
        r.fd     = 16'hFFFF;
        lo       = c.handle[31:0];
        hi       = c.handle[63:32];
        s        = decode_handle(v, c.handle);
        case (c.cmd)
            CMD_ALLOC_FD, CMD_ALLOC_OBJ: begin
                s = lowest_free(v);
                if (c.cmd == CMD_ALLOC_FD && c.fdesc[15]) begin
                    r.status = STS_BAD_ARG;
                end else if (c.cmd == CMD_ALLOC_OBJ && (c.tag == '0 ||
                             c.okind < KIND_FIND || c.okind > KIND_CHANGE)) begin
                    r.status = STS_BAD_ARG;
                end else if (s < 0) begin
                    r.status = STS_FULL;
                end else begin
                    ent_used[v][s] = 1'b1;
                    live_cnt[v]    = live_cnt[v] + 1'b1;
                    if (c.cmd == CMD_ALLOC_FD) begin
                        ent_kind[v][s]     = KIND_FD;
                        ent_fd[v][s]       = c.fdesc;
                        ent_closable[v][s] = c.closable;
                        ent_object[v][s]   = '0;
                        ent_hook[v][s]     = 1'b0;
                    end else begin
                        ent_kind[v][s]     = c.okind;
                        ent_fd[v][s]       = 16'hFFFF;
                        ent_closable[v][s] = 1'b1;
                        ent_object[v][s]   = c.tag;
                        ent_hook[v][s]     = c.hook;
                    end
                    r.handle = 32'(s + BIAS);
                end
            end
            CMD_TO_FD: begin
                // standard selectors win over the table
                if ((hi == '0 || hi[31]) && lo >= 32'hFFFF_FFF4 && lo <= 32'hFFFF_FFF6)
                    r.fd = 16'(32'hFFFF_FFF6 - lo);
                else if (s < 0)
                    r.status = STS_INVALID;
                else if (ent_kind[v][s] != KIND_FD)
                    r.status = STS_WRONG_KIND;
                else
                    r.fd = ent_fd[v][s];
            end
            CMD_KIND_OF: begin
                if (s < 0) r.status = STS_INVALID;
                else       r.kind = ent_kind[v][s];
            end
            CMD_GET_OBJ, CMD_RELEASE_OBJ: begin
                if (s < 0) begin
                    r.status = STS_INVALID;
                end else if (ent_kind[v][s] != c.okind) begin
                    r.status = STS_WRONG_KIND;
                end else begin
                    r.object = ent_object[v][s];
                    if (c.cmd == CMD_RELEASE_OBJ) wipe_entry(v, s);
                end
            end
            CMD_RELEASE: begin
                if (s < 0) begin
                    r.status = STS_INVALID;
                end else if (ent_kind[v][s] == KIND_FIND || ent_kind[v][s] == KIND_CHANGE) begin
                    r.status = STS_FIND_CLOSE;
                end else if (ent_kind[v][s] == KIND_MAP || ent_kind[v][s] == KIND_PROC) begin
                    r.object      = ent_object[v][s];
                    r.free_needed = ent_hook[v][s];
                    wipe_entry(v, s);
                end else if (!ent_closable[v][s]) begin
                    r.status = STS_NOT_CLOSABLE;
                end else begin
                    r.fd = ent_fd[v][s];
                    wipe_entry(v, s);
                end
            end
            default: r.status = STS_BAD_ARG;
        endcase
        r.live = live_cnt[v];
        return r;
    endfunction

    // ------------------------------------------------------------ stimulus

    function automatic void queue_cmd(input t_cmd_beat c);
        void'(step_table(PLAN, c));
        cmd_q.push_back(c);
    endfunction

    function automatic t_cmd_beat mk_cmd(input t_cmd op, input logic [63:0] h);
        t_cmd_beat c;
        c        = '0;
        c.cmd    = op;
        c.handle = h;
        return c;
    endfunction

    function automatic t_cmd_beat mk_obj(input logic [2:0] k, input logic [31:0] tag,
                                         input logic hook);
        t_cmd_beat c;
        c       = mk_cmd(CMD_ALLOC_OBJ, '0);
        c.okind = k;
        c.tag   = tag;
        c.hook  = hook;
        return c;
    endfunction

    // a random in-use slot of the planned table; standard slots less often
    function automatic int pick_slot();
        int pool[$];
        for (int i = 0; i < SLOTS; i++)
            if (ent_used[PLAN][i] && (i >= STD_SLOTS || $urandom_range(0, 3) == 0))
                pool.push_back(i);
        if (pool.size() == 0) return -1;
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic t_cmd_beat rand_cmd();
        t_cmd_beat c;
        int        w;
        int        s;
        c          = '0;
        c.hook     = 1'($urandom_range(0, 1));
        c.closable = 1'($urandom_range(0, 1));
        c.tag      = ($urandom_range(0, 31) == 0) ? 32'h0 : 32'($urandom);
        c.okind    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
        c.fdesc    = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 32767));
        c.handle   = {32'($urandom), 32'($urandom)};
        w = $urandom_range(0, 99);
        if      (w < 17) c.cmd = CMD_ALLOC_FD;
        else if (w < 34) c.cmd = CMD_ALLOC_OBJ;
        else if (w < 48) c.cmd = CMD_TO_FD;
        else if (w < 58) c.cmd = CMD_KIND_OF;
        else if (w < 70) c.cmd = CMD_GET_OBJ;
        else if (w < 80) c.cmd = CMD_RELEASE_OBJ;
        else if (w < 97) c.cmd = CMD_RELEASE;
        else             c.cmd = CMD_UNKNOWN;
        // mostly aim at a live entry with its own kind; the rest is noise
        s = pick_slot();
        w = $urandom_range(0, 99);
        if (w < 75 && s >= 0) begin
            c.handle = 64'(s + BIAS);
            if ($urandom_range(0, 4) != 0) c.okind = ent_kind[PLAN][s];
        end else if (w < 82) begin
            c.handle = 64'(BIAS + $urandom_range(0, SLOTS - 1));
        end else if (w < 90) begin
            c.handle[31:0] = 32'hFFFF_FFF4 + 32'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0:       c.handle[63:32] = '0;
                1:       c.handle[63:32] = 32'($urandom) | 32'h8000_0000;
                default: c.handle[63:32] = {1'b0, 31'($urandom)};
            endcase
        end
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            err_cnt++;
        end
    endfunction

    task automatic wait_drained();
        while (!(cmd_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0))
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------ driver / monitor

    // sender: predicts on each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(step_table(LIVE, t_cmd_beat'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tdata  <= cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down here; the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp_beat got;
        t_rsp_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_rsp_beat'(m_axis_tdata);
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing pending: %h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status",      32'(want.status),      32'(got.status));
                    check_field("handle_out",  want.handle,           got.handle);
                    check_field("fd_out",      32'(want.fd),          32'(got.fd));
                    check_field("kind_out",    32'(want.kind),        32'(got.kind));
                    check_field("object_out",  want.object,           got.object);
                    check_field("free_needed", 32'(want.free_needed), 32'(got.free_needed));
                    check_field("live_count",  32'(want.live),        32'(got.live));
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------- sequence

    initial begin
        t_cmd_beat c;
        reset_table(LIVE);
        reset_table(PLAN);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: selectors, handle range edges, rejects, every kind and rule
        c = mk_cmd(CMD_TO_FD, 64'h0000_0000_FFFF_FFF6);           queue_cmd(c);
        c = mk_cmd(CMD_TO_FD, 64'hFFFF_FFFF_FFFF_FFF5);           queue_cmd(c);
        c = mk_cmd(CMD_TO_FD, 64'h8000_0000_FFFF_FFF4);           queue_cmd(c);
        c = mk_cmd(CMD_TO_FD, 64'h0000_0001_FFFF_FFF6);           queue_cmd(c); // positive high half
        c = mk_cmd(CMD_TO_FD, 64'(BIAS));                         queue_cmd(c);
        c = mk_cmd(CMD_KIND_OF, 64'(BIAS - 1));                   queue_cmd(c);
        c = mk_cmd(CMD_GET_OBJ, 64'h8000_0000_0000_0100);         queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'h7FFF_FFFF_FFFF_FFFF);         queue_cmd(c);
        c = mk_cmd(CMD_ALLOC_FD, '0); c.fdesc = 16'h8000;         queue_cmd(c);
        c = mk_cmd(CMD_ALLOC_FD, '0); c.fdesc = 16'h7FFF; c.closable = 1'b1;
        queue_cmd(c);                                             // slot 3
        c = mk_cmd(CMD_ALLOC_FD, '0);                             queue_cmd(c); // slot 4
        queue_cmd(mk_obj(KIND_FIND, 32'h0, 1'b0));                // zero tag
        queue_cmd(mk_obj(3'd5, 32'h5, 1'b0));                     // kind out of range
        queue_cmd(mk_obj(KIND_FIND, 32'hFFFF_FFFF, 1'b1));        // slot 5
        queue_cmd(mk_obj(KIND_MAP, 32'h0000_0001, 1'b1));         // slot 6
        queue_cmd(mk_obj(KIND_PROC, 32'h8000_0000, 1'b0));        // slot 7
        queue_cmd(mk_obj(KIND_CHANGE, 32'h1234_5678, 1'b1));      // slot 8
        c = mk_cmd(CMD_TO_FD, 64'(BIAS + 6));                     queue_cmd(c);
        c = mk_cmd(CMD_KIND_OF, 64'(BIAS + 8));                   queue_cmd(c);
        c = mk_cmd(CMD_GET_OBJ, 64'(BIAS + 5)); c.okind = KIND_MAP;  queue_cmd(c);
        c = mk_cmd(CMD_GET_OBJ, 64'(BIAS + 5)); c.okind = KIND_FIND; queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'(BIAS + 5));                   queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'(BIAS + 6));                   queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'(BIAS + 7));                   queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'(BIAS + 4));                   queue_cmd(c);
        c = mk_cmd(CMD_RELEASE, 64'(BIAS + 3));                   queue_cmd(c);
        c = mk_cmd(CMD_RELEASE_OBJ, 64'(BIAS + 8)); c.okind = KIND_CHANGE; queue_cmd(c);
        c = mk_cmd(CMD_RELEASE_OBJ, 64'(BIAS + 5)); c.okind = KIND_FIND;   queue_cmd(c);
        // release_obj may clear a standard stream slot too
        c = mk_cmd(CMD_RELEASE_OBJ, 64'(BIAS + 2)); c.okind = KIND_FD;     queue_cmd(c);
        c = mk_cmd(CMD_UNKNOWN, 64'(BIAS));                       queue_cmd(c);
        wait_drained();

        // fill the table to full behind a long receiver hold-off, then empty it
        hold_go = 1'b1;
        while (lowest_free(PLAN) >= 0) begin
            if ($urandom_range(0, 1) == 0) begin
                c = mk_cmd(CMD_ALLOC_FD, '0);
                c.fdesc    = 16'($urandom_range(0, 32767));
                c.closable = 1'($urandom_range(0, 1));
            end else begin
                c = mk_obj(3'($urandom_range(1, 4)), 32'($urandom_range(1, 32'h7FFF_FFFF)),
                           1'($urandom_range(0, 1)));
            end
            queue_cmd(c);
        end
        c = mk_cmd(CMD_ALLOC_FD, '0);                             queue_cmd(c);
        queue_cmd(mk_obj(KIND_MAP, 32'hCAFE_0001, 1'b1));
        for (int i = STD_SLOTS; i < SLOTS; i++) begin
            c = mk_cmd(CMD_RELEASE, 64'(BIAS + i));
            if (ent_kind[PLAN][i] == KIND_FIND || ent_kind[PLAN][i] == KIND_CHANGE ||
                (ent_kind[PLAN][i] == KIND_FD && !ent_closable[PLAN][i])) begin
                c.cmd   = CMD_RELEASE_OBJ;
                c.okind = ent_kind[PLAN][i];
            end
            queue_cmd(c);
        end
        @(negedge i_clk);
        hold_go = 1'b0;
        wait_drained();

        // random phases: free flow, sender gaps, receiver stalls, light mix
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_cmd(rand_cmd());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/bht_pkg.sv
rtl/bht_ram.sv
rtl/biased_handle_table.sv
tb/sv/tb.sv
